>>> rtl/core/tlshc_pkg.sv
// Shared types and constants for the TLS record header counter.
`default_nettype none

package tlshc_pkg;

  // Header field values
  localparam logic [7:0] TYPE_LOW      = 8'h14;
  localparam logic [7:0] TYPE_HIGH     = 8'h17;
  localparam logic [7:0] MAJOR_VERSION = 8'h03;
  localparam logic [7:0] MINOR_MAX     = 8'h04;
  localparam int unsigned HEADER_SIZE  = 5;

  // Result width on the stream
  localparam int unsigned OUT_WIDTH = 16;

  // One payload word as held in the input register
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/tls_record_header_counter_core.sv
// Top level: input register, header scanner and result register on stream ports.
// The scanner state updates only when a held word moves on into it.
// Throughput: one payload word per cycle unless a last word waits (below).
// A last word waits in the input register only while an earlier count is untaken.
// Reset (rst_ni low, asynchronous): scanner cleared to scanning, count zero,
// both registers empty.
`default_nettype none

module tls_record_header_counter_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [15:0] header_bytes
);

  logic                                 in_valid_q;
  tlshc_pkg::item_t                     in_item_q;
  logic                                 advance;
  logic                                 out_valid_q;
  logic [tlshc_pkg::OUT_WIDTH-1:0]      out_data_q;
  logic [tlshc_pkg::OUT_WIDTH-1:0]      count;

  // A held word moves on unless it needs the result slot and that is full
  assign advance = in_valid_q &&
                   (!in_item_q.last || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= '{last: s_axis_tlast, data: s_axis_tdata};
    end
  end

  tlshc_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .count_o(count)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_item_q.last) begin
      out_data_q <= count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/tlshc_scan.sv
// Per-byte header scanner: scan state, body skip counter and header count.
`default_nettype none

module tlshc_scan #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,     // process item_i this cycle
  input  wire tlshc_pkg::item_t              item_i,
  output logic [tlshc_pkg::OUT_WIDTH-1:0]    count_o   // count after item_i, for a last word
);

  localparam logic [1:0] PH_SCAN   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [15:0]            win_q, win_d;
  logic [1:0]             fill_q, fill_d;
  logic [1:0]             phase_q, phase_d;
  logic [7:0]             len_hi_q, len_hi_d;
  logic [15:0]            skip_q, skip_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;

  logic [COUNT_WIDTH:0]   total_sum;
  logic [COUNT_WIDTH-1:0] total_sat;
  logic                   hdr_hit;
  logic [7:0]             older;
  logic [7:0]             newer;

  assign older = win_q[15:8];
  assign newer = win_q[7:0];

  // Header match on the third byte of a candidate
  assign hdr_hit = (fill_q == 2'd2) && (older >= tlshc_pkg::TYPE_LOW) &&
                   (older <= tlshc_pkg::TYPE_HIGH) &&
                   (newer == tlshc_pkg::MAJOR_VERSION) &&
                   (item_i.data <= tlshc_pkg::MINOR_MAX);

  // Saturating add of one header
  assign total_sum = {1'b0, total_q} + (COUNT_WIDTH+1)'(tlshc_pkg::HEADER_SIZE);
  assign total_sat = total_sum[COUNT_WIDTH] ? COUNT_MAX : total_sum[COUNT_WIDTH-1:0];

  // Next-state logic
  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    skip_d   = skip_q;
    total_d  = total_q;

    unique case (phase_q)
      PH_SCAN: begin
        if (hdr_hit) begin
          total_d = total_sat;
          win_d   = '0;
          fill_d  = '0;
          phase_d = PH_LEN_HI;
        end else begin
          win_d = {win_q[7:0], item_i.data};
          if (fill_q != 2'd2) begin
            fill_d = fill_q + 2'd1;
          end
        end
      end
      PH_LEN_HI: begin
        len_hi_d = item_i.data;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        skip_d  = {len_hi_q, item_i.data};
        phase_d = ({len_hi_q, item_i.data} == 16'd0) ? PH_SCAN : PH_SKIP;
      end
      PH_SKIP: begin
        if (skip_q != 16'd0) begin
          skip_d = skip_q - 16'd1;
        end
        if (skip_q <= 16'd1) begin
          phase_d = PH_SCAN;
        end
      end
      default: begin
        phase_d = PH_SCAN;
      end
    endcase

    // End of packet: report and clear
    if (item_i.last) begin
      win_d    = '0;
      fill_d   = '0;
      phase_d  = PH_SCAN;
      len_hi_d = '0;
      skip_d   = '0;
      total_d  = '0;
    end
  end

  // Count reported for a last word, taken before the clear
  assign count_o = (phase_q == PH_SCAN && hdr_hit)
                 ? tlshc_pkg::OUT_WIDTH'(total_sat)
                 : tlshc_pkg::OUT_WIDTH'(total_q);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      phase_q  <= PH_SCAN;
      len_hi_q <= '0;
      skip_q   <= '0;
      total_q  <= '0;
    end else if (en_i) begin
      win_q    <= win_d;
      fill_q   <= fill_d;
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      skip_q   <= skip_d;
      total_q  <= total_d;
    end
  end

  // A body being skipped always has bytes left
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != 16'd0))
    else $error("skip phase with empty body counter");

  // Window fill never passes two
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("window fill out of range");

  // A last word leaves the scanner cleared
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.last) |=> (phase_q == PH_SCAN && total_q == '0 && fill_q == 2'd0))
    else $error("state not cleared after last word");

  // Count only moves on processed words
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(total_q))
    else $error("count changed without a word");

endmodule

`default_nettype wire
